[hdl/brms_pkg.sv]
`timescale 1ns / 1ps

package brms_pkg;

  // Field widths fixed by the sample and result formats
  localparam int SAMPLE_W      = 16;
  localparam int SQ_W          = 31;  // square of a 16-bit magnitude, up to 2^30
  localparam int MEAN_W        = 32;  // radicand width of the root unit
  localparam int ROOT_W        = 16;
  localparam int CTR_W         = 32;
  localparam int MAX_BATCH_DEF = 1024;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // take a sample transfer, register its square
    logic add;         // fold the square into the batch, start divide on last
    logic div_step;    // one quotient bit
    logic sqrt_init;   // load root unit from the quotient
    logic sqrt_step;   // one root bit
    logic load;        // load the result register, bump counters
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;        // captured sample closes its batch
    logic div_last;    // current divide step is the final one
    logic sqrt_last;   // current root step is the final one
    logic out_free;    // result register can take a new result this cycle
  } sts_t;

endpackage

[hdl/brms_ctrl.sv]
`timescale 1ns / 1ps

module brms_ctrl
  import brms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic samp_valid,
  output logic samp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQI  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Sequencer: capture, accumulate, divide, root, hand off
  always_comb begin
    state_next = state;
    cmd        = '0;
    samp_stall = 1'b1;
    case (state)
      S_IDLE: begin
        samp_stall = 1'b0;
        if (samp_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = sts.last ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_SQI;
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_add: assert property (@(posedge clk) disable iff (rst)
    (samp_valid && !samp_stall) |=> state == S_ADD)
    else $error("sample transfer did not move to accumulate");
  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !sts.div_last) |=> state == S_DIV)
    else $error("divide left early");
  a_out_release: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && sts.out_free) |=> state == S_IDLE)
    else $error("result load did not return to idle");
`endif

endmodule

[hdl/brms_dp.sv]
`timescale 1ns / 1ps

module brms_dp
  import brms_pkg::*;
#(
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic                       overrun,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [ROOT_W-1:0]          rms_level,
  output logic [CTR_W-1:0]           batch_total,
  output logic [CTR_W-1:0]           overrun_total,
  output logic                       too_long
);

  localparam int CNT_W  = $clog2(MAX_BATCH + 1);
  localparam int SUM_W  = SQ_W + $clog2(MAX_BATCH);
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BATCH);

  // Batch state
  logic [SUM_W-1:0]  square_sum;
  logic [CNT_W-1:0]  sample_count;
  logic              overflow_seen;
  logic [CTR_W-1:0]  batch_counter;
  logic [CTR_W-1:0]  overrun_counter;

  // Captured sample
  logic [SQ_W-1:0]   square;
  logic              last_r;
  logic              over_r;
  logic              tl_r;

  // Divider and root unit
  logic [SUM_W-1:0]  quot;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  divisor;
  logic [MEAN_W-1:0] rad;
  logic [MEAN_W-1:0] root;
  logic [MEAN_W-1:0] one;
  logic [STEP_W-1:0] step;

  logic [SAMPLE_W-1:0] mag;
  logic                full;
  logic [SUM_W-1:0]    sum_upd;
  logic [CNT_W-1:0]    cnt_upd;
  logic [CNT_W:0]      div_trial;
  logic                div_fit;
  logic [MEAN_W:0]     sq_trial;
  logic                sq_fit;

  // Magnitude of the sample; the most negative value wraps to 0x8000 unsigned
  assign mag = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);

  // Accumulate unless the batch is already full
  assign full    = (sample_count == CNT_MAX);
  assign sum_upd = full ? square_sum : square_sum + SUM_W'(square);
  assign cnt_upd = full ? sample_count : sample_count + 1'b1;

  // Restoring divide, one quotient bit per step
  assign div_trial = {rem, quot[SUM_W-1]};
  assign div_fit   = (div_trial >= {1'b0, divisor});

  // Restoring root, one result bit per step
  assign sq_trial = {1'b0, root} + {1'b0, one};
  assign sq_fit   = ({1'b0, rad} >= sq_trial);

  assign sts.last      = last_r;
  assign sts.div_last  = (step == DIV_LAST);
  assign sts.sqrt_last = (step == SQRT_LAST);
  assign sts.out_free  = !res_valid || !res_stall;

  // Capture and arithmetic datapath
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      square <= SQ_W'(mag) * SQ_W'(mag);
      last_r <= last;
      over_r <= overrun;
    end
    if (cmd.add && last_r) begin
      quot    <= (cnt_upd == '0) ? '0 : sum_upd;
      divisor <= cnt_upd;
      rem     <= '0;
      tl_r    <= overflow_seen | full;
    end
    if (cmd.div_step) begin
      if (div_fit) begin
        rem  <= CNT_W'(div_trial - {1'b0, divisor});
        quot <= {quot[SUM_W-2:0], 1'b1};
      end else begin
        rem  <= CNT_W'(div_trial);
        quot <= {quot[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_init) begin
      rad  <= MEAN_W'(quot);
      root <= '0;
      one  <= MEAN_W'(1) << (MEAN_W - 2);
    end
    if (cmd.sqrt_step) begin
      if (sq_fit) begin
        rad  <= rad - MEAN_W'(sq_trial);
        root <= (root >> 1) + one;
      end else begin
        root <= root >> 1;
      end
      one <= one >> 2;
    end
    if (cmd.load) begin
      rms_level     <= ROOT_W'(root);
      batch_total   <= batch_counter + 1'b1;
      overrun_total <= overrun_counter + CTR_W'(over_r);
      too_long      <= tl_r;
    end
  end

  // Step counter shared by divide and root
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if ((cmd.add && last_r) || cmd.sqrt_init) begin
      step <= '0;
    end else if (cmd.div_step || cmd.sqrt_step) begin
      step <= step + 1'b1;
    end
  end

  // Batch accumulators and running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum      <= '0;
      sample_count    <= '0;
      overflow_seen   <= 1'b0;
      batch_counter   <= '0;
      overrun_counter <= '0;
    end else begin
      if (cmd.add) begin
        if (last_r) begin
          square_sum    <= '0;
          sample_count  <= '0;
          overflow_seen <= 1'b0;
        end else begin
          square_sum    <= sum_upd;
          sample_count  <= cnt_upd;
          overflow_seen <= overflow_seen | full;
        end
      end
      if (cmd.load) begin
        batch_counter   <= batch_counter + 1'b1;
        overrun_counter <= overrun_counter + CTR_W'(over_r);
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_rms_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> rms_level <= 16'h8000)
    else $error("rms level out of range");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_MAX)
    else $error("sample count past batch limit");
  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> batch_total == batch_counter)
    else $error("batch total out of step with counter");
`endif

endmodule

[hdl/batch_rms_level_meter_core.sv]
`timescale 1ns / 1ps
// A non-final sample is squared, then accumulated, before the next one is taken.
// A final sample then passes through a one-bit-per-cycle divider (SUM_W
// steps) and a one-bit-per-cycle root unit (16 steps) before its result is
// loaded; the load waits while the result register is full and stalled.
// The result register lets the next batch start while a result waits.
// Synchronous active-high reset clears sums, counts, running counters and valid.

module batch_rms_level_meter_core
  import brms_pkg::*;
#(
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       samp_valid,
  output logic                       samp_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  input  logic                       overrun,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [ROOT_W-1:0]          rms_level,
  output logic [CTR_W-1:0]           batch_total,
  output logic [CTR_W-1:0]           overrun_total,
  output logic                       too_long
);

  cmd_t cmd;
  sts_t sts;

  brms_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .samp_valid (samp_valid),
    .samp_stall (samp_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  brms_dp #(
    .MAX_BATCH (MAX_BATCH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .sample        (sample),
    .last          (last),
    .overrun       (overrun),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .rms_level     (rms_level),
    .batch_total   (batch_total),
    .overrun_total (overrun_total),
    .too_long      (too_long)
  );

endmodule

[tb/tb_batch_rms_level_meter_core.sv]
`timescale 1ns / 1ps

module tb_batch_rms_level_meter_core;
  import brms_pkg::*;

  localparam int BATCH_LIMIT = MAX_BATCH_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       is_last;
    logic                       lost;
  } mic_sample_t;

  typedef struct {
    logic [ROOT_W-1:0] rms;
    logic [CTR_W-1:0]  batches;
    logic [CTR_W-1:0]  overruns;
    logic              cut;
  } meter_report_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       samp_valid = 1'b0;
  logic                       samp_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last = 1'b0;
  logic                       overrun = 1'b0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [ROOT_W-1:0]          rms_level;
  logic [CTR_W-1:0]           batch_total;
  logic [CTR_W-1:0]           overrun_total;
  logic                       too_long;

  // stimulus and scoreboard storage
  mic_sample_t   samples_to_send[$];
  meter_report_t meter_reports_due[$];
  int unsigned   n_queued = 0;
  int unsigned   n_accepted = 0;
  int unsigned   n_errors = 0;
  int unsigned   cycle_count = 0;
  bit            idle_on = 1'b1;
  int unsigned   hold_requests = 0;
  int unsigned   holds_served = 0;

  // driver and receiver pacing
  logic        samp_fire = 1'b0;
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  // predictor state
  logic [63:0]    sum_sq = '0;
  int unsigned    batch_fill = 0;
  logic           batch_cut = 1'b0;
  logic [CTR_W-1:0] batches_done = '0;
  logic [CTR_W-1:0] overruns_done = '0;

  batch_rms_level_meter_core #(
    .MAX_BATCH(BATCH_LIMIT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .samp_valid   (samp_valid),
    .samp_stall   (samp_stall),
    .sample       (sample),
    .last         (last),
    .overrun      (overrun),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .rms_level    (rms_level),
    .batch_total  (batch_total),
    .overrun_total(overrun_total),
    .too_long     (too_long)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor of the square root, one bit at a time from the top
  function automatic logic [ROOT_W-1:0] root_floor(input logic [63:0] radicand);
    logic [ROOT_W-1:0] root;
    logic [63:0]       cand;
    root = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      cand = 64'(root | (ROOT_W'(1) << b));
      if (cand * cand <= radicand) root[b] = 1'b1;
    end
    return root;
  endfunction

  // fold one transfer into the batch; a closing sample yields a report
  task automatic meter_absorb(input logic signed [SAMPLE_W-1:0] value,
                              input logic is_last, input logic lost);
    logic [16:0]   mag;
    logic [63:0]   mean;
    meter_report_t rep;
    mag = value[SAMPLE_W-1] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
    if (batch_fill < BATCH_LIMIT) begin
      sum_sq = sum_sq + 64'(mag) * 64'(mag);
      batch_fill++;
    end else begin
      batch_cut = 1'b1;
    end
    if (is_last) begin
      mean = (batch_fill != 0) ? sum_sq / 64'(batch_fill) : 64'd0;
      batches_done = batches_done + 1'b1;
      if (lost) overruns_done = overruns_done + 1'b1;
      rep.rms      = root_floor(mean);
      rep.batches  = batches_done;
      rep.overruns = overruns_done;
      rep.cut      = batch_cut;
      meter_reports_due.push_back(rep);
      sum_sq     = '0;
      batch_fill = 0;
      batch_cut  = 1'b0;
    end
  endtask

  task automatic queue_sample(input int v, input logic is_last, input logic lost);
    mic_sample_t s;
    s.value   = SAMPLE_W'(v);
    s.is_last = is_last;
    s.lost    = lost;
    samples_to_send.push_back(s);
    n_queued++;
  endtask

  // random sample: extremes, full range or quiet signal
  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return 32767;
      2: return int'($urandom_range(0, 2)) - 1;
      3, 4: return int'($urandom_range(0, 511)) - 256;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // a loud batch is mostly full scale, to push the sum of squares high
  task automatic queue_batch(input int len, input bit loud);
    int v;
    for (int i = 0; i < len; i++) begin
      v = (loud && $urandom_range(0, 15) != 0) ? -32768 : pick_sample();
      queue_sample(v, i == len - 1, $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic wait_meter_drained();
    while (samples_to_send.size() != 0 || n_accepted != n_queued ||
           meter_reports_due.size() != 0)
      @(posedge clk);
  endtask

  // sample driver: pops the next transfer once the current one is taken
  always @(negedge clk) begin
    mic_sample_t nxt;
    if (rst) begin
      samp_valid <= 1'b0;
    end else if (!samp_valid || samp_fire) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        samp_valid <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        nxt = samples_to_send.pop_front();
        samp_valid <= 1'b1;
        sample     <= nxt.value;
        last       <= nxt.is_last;
        overrun    <= nxt.lost;
        if (idle_on && calm_left == 0 && $urandom_range(0, 3) == 0)
          gap_left <= $urandom_range(1, 15);
        else if (calm_left > 0)
          calm_left <= calm_left - 1;
        else if ($urandom_range(0, 15) == 0)
          calm_left <= $urandom_range(10, 40);
      end else begin
        samp_valid <= 1'b0;
      end
    end
  end

  // result stall: random bursts, plus a long hold on request
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      res_stall    <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 14);
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // monitor: predict on sample transfers, check on result transfers
  always @(posedge clk) begin
    meter_report_t want;
    samp_fire <= samp_valid && !samp_stall;
    if (!rst && samp_valid && !samp_stall) begin
      meter_absorb(sample, last, overrun);
      n_accepted++;
    end
    if (!rst && res_valid && !res_stall) begin
      if (meter_reports_due.size() == 0) begin
        $error("result transfer with no report pending: rms_level %0d", rms_level);
        n_errors++;
      end else begin
        want = meter_reports_due.pop_front();
        if (rms_level !== want.rms) begin
          $error("rms_level: expected %0d, got %0d", want.rms, rms_level);
          n_errors++;
        end
        if (batch_total !== want.batches) begin
          $error("batch_total: expected %0d, got %0d", want.batches, batch_total);
          n_errors++;
        end
        if (overrun_total !== want.overruns) begin
          $error("overrun_total: expected %0d, got %0d", want.overruns, overrun_total);
          n_errors++;
        end
        if (too_long !== want.cut) begin
          $error("too_long: expected %0d, got %0d", want.cut, too_long);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-sample batches at full scale and around zero
    queue_sample(-32768, 1'b1, 1'b1);
    queue_sample(32767, 1'b1, 1'b0);
    queue_sample(0, 1'b1, 1'b0);
    queue_sample(-1, 1'b1, 1'b1);
    queue_sample(1, 1'b1, 1'b0);
    // overrun on inner samples is ignored
    queue_sample(-1, 1'b0, 1'b1);
    queue_sample(2, 1'b0, 1'b1);
    queue_sample(3, 1'b1, 1'b0);
    // mixed extremes, mean truncates
    queue_sample(32767, 1'b0, 1'b0);
    queue_sample(-32768, 1'b0, 1'b0);
    queue_sample(0, 1'b0, 1'b1);
    queue_sample(-32768, 1'b1, 1'b1);
    // root just below a perfect square
    queue_sample(3, 1'b0, 1'b0);
    queue_sample(4, 1'b1, 1'b0);
    // largest mean
    queue_sample(-32768, 1'b0, 1'b0);
    queue_sample(-32768, 1'b1, 1'b0);
    queue_sample(5, 1'b0, 1'b0);
    queue_sample(7, 1'b0, 1'b1);
    queue_sample(-9, 1'b1, 1'b1);

    // sender waits for every report before going on
    wait_meter_drained();

    // long receiver hold while the sender keeps offering
    hold_requests++;
    while (n_queued < 370)
      queue_batch(($urandom_range(0, 6) != 0) ? $urandom_range(1, 8)
                                              : $urandom_range(9, 48), 1'b0);
    // one batch past the limit, closing sample dropped
    queue_batch(BATCH_LIMIT + 1, 1'b1);
    while (n_queued < 1750)
      queue_batch(($urandom_range(0, 6) != 0) ? $urandom_range(1, 8)
                                              : $urandom_range(9, 48), 1'b0);

    // last stretch runs at full rate
    while (samples_to_send.size() > 150) @(posedge clk);
    idle_on = 1'b0;

    wait_meter_drained();
    repeat (80) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
